@@ rtl/snie_pkg.sv @@
// ---------------------------------------------------------------------------
// snie_pkg: shared types and constants for the snake internal energy core
// Payload structs, job descriptor, config register codes, back-end states.
// ---------------------------------------------------------------------------
`default_nettype none

package snie_pkg;

  // Field widths of the request and result
  localparam int unsigned COORD_IN_W  = 12;
  localparam int unsigned ENERGY_W    = 63;
  localparam int unsigned PERIM_W     = 29;
  localparam int unsigned CNT_OUT_W   = 9;
  localparam int unsigned WEIGHT_W    = 16;

  // Parameter defaults and limits
  localparam int unsigned MAX_POINTS_DEF = 256;
  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned JOB_CNT_W      = 13;  // holds counts up to 8191

  // Configuration port
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONT_WEIGHT = 1'b0,
    CFG_CURV_WEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_IN_W-1:0] point_x;
    logic [COORD_IN_W-1:0] point_y;
    logic                  last_point;
  } req_t;

  typedef struct packed {
    logic [ENERGY_W-1:0]  energy;
    logic [PERIM_W-1:0]   perimeter;
    logic [CNT_OUT_W-1:0] point_count;
    logic                 overflow;
  } res_t;

  // One closed contour handed from front to back
  typedef struct packed {
    logic [JOB_CNT_W-1:0] count;
    logic                 dropped;
  } job_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_PREV,
    S_RD_CUR,
    S_GET_CUR,
    S_GET_NEXT,
    S_SQ,
    S_ROOT_GO,
    S_ROOT,
    S_DEV,
    S_MUL,
    S_ACC,
    S_ISSUE,
    S_DIV,
    S_MAC,
    S_FIN
  } back_state_e;

endpackage

`default_nettype wire

@@ rtl/snie_ram.sv @@
// ---------------------------------------------------------------------------
// snie_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module snie_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/snie_front.sv @@
// ---------------------------------------------------------------------------
// snie_front: point loader
// Writes accepted points into the store and closes a contour into a job.
// ---------------------------------------------------------------------------
`default_nettype none

module snie_front #(
  parameter int unsigned MAX_POINTS = snie_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = snie_pkg::COORD_BITS_DEF,
  localparam int unsigned AW        = $clog2(MAX_POINTS),
  localparam int unsigned CW        = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire snie_pkg::req_t        req_i,
  output logic                       we_o,
  output logic [AW-1:0]              waddr_o,
  output logic [2*COORD_BITS-1:0]    wdata_o,
  output logic                       push_o,
  output snie_pkg::job_t             job_o
);

  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic          full;
  logic [CW-1:0] n_closed;

  assign full = (count_q == CW'(MAX_POINTS));

  // store write
  assign we_o    = accept_i && !full;
  assign waddr_o = count_q[AW-1:0];
  assign wdata_o = {COORD_BITS'(req_i.point_x), COORD_BITS'(req_i.point_y)};

  // contour close
  assign n_closed      = full ? count_q : count_q + CW'(1);
  assign push_o        = accept_i && req_i.last_point;
  assign job_o.count   = snie_pkg::JOB_CNT_W'(n_closed);
  assign job_o.dropped = drop_q || full;

  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    if (accept_i) begin
      if (req_i.last_point) begin
        count_d = '0;
        drop_d  = 1'b0;
      end else if (full) begin
        drop_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/snie_jobq.sv @@
// ---------------------------------------------------------------------------
// snie_jobq: two-entry job queue
// Decouples the point loader from the energy back end.
// ---------------------------------------------------------------------------
`default_nettype none

module snie_jobq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire snie_pkg::job_t job_i,
  input  wire logic           pop_i,
  output logic                valid_o,
  output snie_pkg::job_t      job_o
);

  snie_pkg::job_t ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

@@ rtl/snie_root.sv @@
// ---------------------------------------------------------------------------
// snie_root: bit-serial integer square root
// Restoring method, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module snie_root #(
  parameter int unsigned DW = 21,
  localparam int unsigned RW = 2 * DW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [RW-1:0] rad_i,
  output logic               done_o,
  output logic [DW-1:0]      root_o
);

  localparam int unsigned NW = $clog2(DW);

  logic          act_q, done_q;
  logic [NW-1:0] cnt_q;
  logic [RW-1:0] rad_q;
  logic [DW+1:0] rem_q;
  logic [DW-1:0] res_q;

  logic [DW+3:0] rem2, trial;
  logic          ge;

  // one restoring step
  assign rem2  = {rem_q, rad_q[RW-1 -: 2]};
  assign trial = {2'b00, res_q, 2'b01};
  assign ge    = (rem2 >= trial);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q <= rad_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (act_q) begin
      rad_q <= rad_q << 2;
      rem_q <= ge ? (DW+2)'(rem2 - trial) : (DW+2)'(rem2);
      res_q <= {res_q[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + NW'(1);
        if (cnt_q == NW'(DW - 1)) begin
          act_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule

`default_nettype wire

@@ rtl/snie_back.sv @@
// ---------------------------------------------------------------------------
// snie_back: energy back end
// Two passes over the store: perimeter, then continuity and curvature;
// serial divide for the mean edge length and a chunked weight multiply.
// ---------------------------------------------------------------------------
`default_nettype none

module snie_back #(
  parameter int unsigned MAX_POINTS = snie_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = snie_pkg::COORD_BITS_DEF,
  localparam int unsigned AW        = $clog2(MAX_POINTS),
  localparam int unsigned CW        = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            job_valid_i,
  input  wire snie_pkg::job_t                  job_i,
  output logic                                 job_pop_o,
  output logic [AW-1:0]                        raddr_o,
  input  wire logic [2*COORD_BITS-1:0]         rdata_i,
  input  wire logic [snie_pkg::WEIGHT_W-1:0]   alpha_i,
  input  wire logic [snie_pkg::WEIGHT_W-1:0]   beta_i,
  output logic                                 busy_o,
  output logic                                 res_valid_o,
  output snie_pkg::res_t                       res_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned SQW  = 2 * CB + 1;         // dx^2 + dy^2
  localparam int unsigned DW   = CB + 9;             // edge length, 8 frac
  localparam int unsigned RW   = 2 * DW;
  localparam int unsigned PW   = DW + CW;            // perimeter sum
  localparam int unsigned QW   = PW + 8;             // divide width
  localparam int unsigned QNW  = $clog2(QW);
  localparam int unsigned DVW  = DW + 8;             // deviation, 16 frac
  localparam int unsigned CTW  = 2 * DVW - 16;       // continuity term
  localparam int unsigned CVW  = 2 * CB + 4 + CW;    // curvature sum
  localparam int unsigned EW   = snie_pkg::ENERGY_W;
  localparam int unsigned WW   = snie_pkg::WEIGHT_W;

  snie_pkg::back_state_e state_q, state_d;

  logic [CW-1:0]  n_q, i_q;
  logic           drop_q, pass_q;
  logic [CB-1:0]  px_q, py_q, cx_q, cy_q, nx_q, ny_q;
  logic [SQW-1:0] dsq_q;
  logic [2*CB+4:0] cvx_q;
  logic [DW-1:0]  d_q;
  logic [PW-1:0]  perim_q;
  logic [QW-1:0]  dq_q;
  logic [CW-1:0]  drem_q;
  logic [QNW-1:0] dcnt_q;
  logic [DVW-1:0] dev_q;
  logic [CTW-1:0] cterm_q;
  logic [63:0]    cont_q;
  logic [CVW-1:0] curv_q;
  logic [1:0]     mstep_q;
  logic [79:0]    acc_q, ea_q;
  logic           res_valid_q;
  snie_pkg::res_t res_q;

  // ring neighbor index
  logic [CW-1:0] ip1;
  logic [AW-1:0] nxt_idx, last_idx;
  logic [CW-1:0] nm1;
  assign ip1      = i_q + CW'(1);
  assign nxt_idx  = (ip1 == n_q) ? '0 : ip1[AW-1:0];
  assign nm1      = n_q - CW'(1);
  assign last_idx = nm1[AW-1:0];

  // edge and curvature terms
  logic [CB-1:0]   rx, ry, dx, dy;
  logic [2*CB-1:0] dx2, dy2;
  logic [CB+1:0]   sx, tx, mx, sy, ty, my;
  logic [2*CB+3:0] mx2, my2;
  assign rx  = rdata_i[2*CB-1:CB];
  assign ry  = rdata_i[CB-1:0];
  assign dx  = (cx_q > nx_q) ? cx_q - nx_q : nx_q - cx_q;
  assign dy  = (cy_q > ny_q) ? cy_q - ny_q : ny_q - cy_q;
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign sx  = (CB+2)'(nx_q) + (CB+2)'(px_q);
  assign tx  = {1'b0, cx_q, 1'b0};
  assign mx  = (sx > tx) ? sx - tx : tx - sx;
  assign sy  = (CB+2)'(ny_q) + (CB+2)'(py_q);
  assign ty  = {1'b0, cy_q, 1'b0};
  assign my  = (sy > ty) ? sy - ty : ty - sy;
  assign mx2 = mx * mx;
  assign my2 = my * my;

  // square root unit
  logic          root_start, root_done;
  logic [DW-1:0] root_val;
  assign root_start = (state_q == snie_pkg::S_ROOT_GO);

  snie_root #(.DW(DW)) u_root (
    .clk_i,
    .rst_ni,
    .start_i (root_start),
    .rad_i   (RW'({dsq_q, 16'h0000})),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  // serial divide step
  logic [CW:0]   rem2;
  logic          dge;
  assign rem2 = {drem_q, dq_q[QW-1]};
  assign dge  = (rem2 >= {1'b0, n_q});

  // deviation and its square
  logic [DVW-1:0]   d16;
  logic [2*DVW-1:0] dev2;
  assign d16  = {d_q, 8'h00};
  assign dev2 = dev_q * dev_q;

  logic [64:0] cont_nxt;
  assign cont_nxt = {1'b0, cont_q} + 65'(cterm_q);

  // weight multiply, 16 x 32 per step, MSB chunk first
  logic [63:0]   curv64;
  logic [WW-1:0] wsel;
  logic [31:0]   chunk;
  logic [47:0]   mprod;
  logic [79:0]   acc_d;
  assign curv64 = 64'(curv_q);
  always_comb begin
    case (mstep_q)
      2'd0:    begin wsel = alpha_i; chunk = cont_q[63:32]; end
      2'd1:    begin wsel = alpha_i; chunk = cont_q[31:0];  end
      2'd2:    begin wsel = beta_i;  chunk = curv64[63:32]; end
      default: begin wsel = beta_i;  chunk = curv64[31:0];  end
    endcase
  end
  assign mprod = wsel * chunk;
  assign acc_d = (mstep_q[0] ? (acc_q << 32) : 80'h0) + 80'(mprod);

  // final sum and saturation
  logic [88:0] esum;
  assign esum = 89'(ea_q[79:8]) + {1'b0, acc_q, 8'h00};

  // next state and outputs
  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    raddr_o   = nxt_idx;
    case (state_q)
      snie_pkg::S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = snie_pkg::S_RD_PREV;
        end
      end
      snie_pkg::S_RD_PREV: begin
        raddr_o = last_idx;
        state_d = snie_pkg::S_RD_CUR;
      end
      snie_pkg::S_RD_CUR: begin
        raddr_o = '0;
        state_d = snie_pkg::S_GET_CUR;
      end
      snie_pkg::S_GET_CUR:  state_d = snie_pkg::S_GET_NEXT;
      snie_pkg::S_GET_NEXT: state_d = snie_pkg::S_SQ;
      snie_pkg::S_SQ:       state_d = snie_pkg::S_ROOT_GO;
      snie_pkg::S_ROOT_GO:  state_d = snie_pkg::S_ROOT;
      snie_pkg::S_ROOT: begin
        if (root_done) state_d = pass_q ? snie_pkg::S_DEV : snie_pkg::S_ACC;
      end
      snie_pkg::S_DEV: state_d = snie_pkg::S_MUL;
      snie_pkg::S_MUL: state_d = snie_pkg::S_ACC;
      snie_pkg::S_ACC: begin
        if (ip1 == n_q) state_d = pass_q ? snie_pkg::S_MAC : snie_pkg::S_DIV;
        else            state_d = snie_pkg::S_ISSUE;
      end
      snie_pkg::S_ISSUE: state_d = snie_pkg::S_GET_NEXT;
      snie_pkg::S_DIV: begin
        if (dcnt_q == QNW'(QW - 1)) state_d = snie_pkg::S_RD_PREV;
      end
      snie_pkg::S_MAC: begin
        if (mstep_q == 2'd3) state_d = snie_pkg::S_FIN;
      end
      snie_pkg::S_FIN: state_d = snie_pkg::S_IDLE;
      default:         state_d = snie_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= snie_pkg::S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == snie_pkg::S_FIN);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      snie_pkg::S_IDLE: begin
        n_q     <= CW'(job_i.count);
        drop_q  <= job_i.dropped;
        pass_q  <= 1'b0;
        perim_q <= '0;
        cont_q  <= '0;
        curv_q  <= '0;
      end
      snie_pkg::S_RD_CUR: begin
        px_q <= rx;
        py_q <= ry;
        i_q  <= '0;
      end
      snie_pkg::S_GET_CUR: begin
        cx_q <= rx;
        cy_q <= ry;
      end
      snie_pkg::S_GET_NEXT: begin
        nx_q <= rx;
        ny_q <= ry;
      end
      snie_pkg::S_SQ: begin
        dsq_q <= SQW'(dx2) + SQW'(dy2);
        cvx_q <= (2*CB+5)'(mx2) + (2*CB+5)'(my2);
      end
      snie_pkg::S_ROOT: begin
        if (root_done) d_q <= root_val;
      end
      snie_pkg::S_DEV: begin
        dev_q <= (d16 > dq_q[DVW-1:0]) ? d16 - dq_q[DVW-1:0] : dq_q[DVW-1:0] - d16;
      end
      snie_pkg::S_MUL: begin
        cterm_q <= dev2[2*DVW-1:16];
      end
      snie_pkg::S_ACC: begin
        if (pass_q) begin
          cont_q <= cont_nxt[64] ? '1 : cont_nxt[63:0];
          curv_q <= curv_q + CVW'(cvx_q);
        end else begin
          perim_q <= perim_q + PW'(d_q);
        end
        px_q <= cx_q;
        py_q <= cy_q;
        cx_q <= nx_q;
        cy_q <= ny_q;
        i_q  <= ip1;
        // set up the divide and the weight multiply
        dq_q    <= pass_q ? dq_q : {perim_q + PW'(d_q), 8'h00};
        drem_q  <= '0;
        dcnt_q  <= '0;
        mstep_q <= 2'd0;
      end
      snie_pkg::S_DIV: begin
        dq_q   <= {dq_q[QW-2:0], dge};
        drem_q <= dge ? CW'(rem2 - {1'b0, n_q}) : rem2[CW-1:0];
        dcnt_q <= dcnt_q + QNW'(1);
        if (dcnt_q == QNW'(QW - 1)) pass_q <= 1'b1;
      end
      snie_pkg::S_MAC: begin
        acc_q   <= acc_d;
        mstep_q <= mstep_q + 2'd1;
        if (mstep_q == 2'd1) ea_q <= acc_d;
      end
      snie_pkg::S_FIN: begin
        res_q.energy      <= (esum > 89'({EW{1'b1}})) ? '1 : esum[EW-1:0];
        res_q.perimeter   <= (64'(perim_q) > 64'({snie_pkg::PERIM_W{1'b1}}))
                             ? '1 : snie_pkg::PERIM_W'(perim_q);
        res_q.point_count <= snie_pkg::CNT_OUT_W'(n_q);
        res_q.overflow    <= drop_q;
      end
      default: begin
      end
    endcase
  end

  assign busy_o      = (state_q != snie_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ rtl/snake_internal_energy_core.sv @@
// ---------------------------------------------------------------------------
// snake_internal_energy_core: internal energy of a closed active contour
// Loads contour points, then reports weighted continuity plus curvature
// energy and the perimeter.
// ---------------------------------------------------------------------------
//  channel  | signals                          | transfer
//  ---------+----------------------------------+--------------------------
//  request  | start, busy, req_i               | start & !busy
//  result   | res_valid_o, res_o               | one-cycle strobe
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i  | cfg_we_i, no wait
//
//  Points load one per cycle while busy is low. The point marked last
//  hands the contour to the back end, which holds busy while it works:
//  each edge runs through the bit-serial square root twice, and the mean
//  edge length comes from a one-bit-per-cycle divider. The result strobe
//  comes in the first idle cycle.
//  After reset the block is idle at once. Results cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module snake_internal_energy_core #(
  parameter int unsigned MAX_POINTS = snie_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = snie_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire snie_pkg::req_t                    req_i,
  output logic                                   res_valid_o,
  output snie_pkg::res_t                         res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [snie_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [snie_pkg::WEIGHT_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  // weight registers
  logic [snie_pkg::WEIGHT_W-1:0] alpha_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= snie_pkg::WEIGHT_W'(1);
      beta_q  <= snie_pkg::WEIGHT_W'(1);
    end else if (cfg_we_i) begin
      case (snie_pkg::cfg_idx_e'(cfg_idx_i))
        snie_pkg::CFG_CONT_WEIGHT: alpha_q <= cfg_data_i;
        snie_pkg::CFG_CURV_WEIGHT: beta_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic                    accept;
  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic [2*COORD_BITS-1:0] wdata, rdata;
  logic                    push, pop, job_valid, back_busy;
  snie_pkg::job_t          job_in, job_out;

  assign accept = start && !busy;
  assign busy   = job_valid || back_busy;

  snie_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i (accept),
    .req_i,
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .push_o   (push),
    .job_o    (job_in)
  );

  snie_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(MAX_POINTS)) u_store (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  snie_jobq u_jobq (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  snie_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .alpha_i     (alpha_q),
    .beta_i      (beta_q),
    .busy_o      (back_busy),
    .res_valid_o,
    .res_o
  );

endmodule

`default_nettype wire

@@ rtl/snie_chk.sv @@
// ---------------------------------------------------------------------------
// snie_chk: port-level checks for the snake internal energy core
// Result strobe timing against busy, and the result of a one-point contour.
// ---------------------------------------------------------------------------
`default_nettype none

module snie_chk (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           busy,
  input wire logic           res_valid_o,
  input wire snie_pkg::res_t res_o
);

  // strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // a result follows a busy period
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(busy))
    else $error("result without preceding work");

  // busy ends only with a result
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("busy dropped without a result");

  // a single point has no length and no energy
  a_one_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.point_count == 9'd1) |->
      (res_o.energy == '0 && res_o.perimeter == '0))
    else $error("one-point contour with nonzero energy");

endmodule

bind snake_internal_energy_core snie_chk u_snie_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench: self-checking bench for snake_internal_energy_core
// Streams contours of random points into the core, predicts perimeter and
// weighted continuity/curvature energy per contour, and checks each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// Expected-result store and checker for contour energy
class energy_scoreboard;
  snie_pkg::res_t pending[$];
  int unsigned    mismatches;
  int unsigned    unexpected;

  function void note_request(snie_pkg::res_t r);
    pending = {pending, r};
  endfunction

  function void check_result(snie_pkg::res_t got);
    snie_pkg::res_t exp_r;
    if (pending.size() == 0) begin
      unexpected++;
      mismatches++;
      if (mismatches <= 10) $display("ERROR: result with none expected: %p", got);
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: mismatch exp e=%0d p=%0d n=%0d o=%0d got e=%0d p=%0d n=%0d o=%0d",
                 exp_r.energy, exp_r.perimeter, exp_r.point_count, exp_r.overflow,
                 got.energy, got.perimeter, got.point_count, got.overflow);
    end
  endfunction
endclass

module testbench;

  localparam int unsigned NPTS      = 256;
  localparam longint unsigned EMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned PMAX  = 64'h1FFF_FFFF;
  localparam longint unsigned LIMIT = 64'd20_000_000;

  logic                clk_i, rst_ni;
  logic                start, busy;
  snie_pkg::req_t      req_i;
  logic                res_valid_o;
  snie_pkg::res_t      res_o;
  logic                cfg_we_i;
  logic [snie_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [snie_pkg::WEIGHT_W-1:0]  cfg_data_i;

  snake_internal_energy_core i_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  energy_scoreboard sb;

  // predictor state
  longint unsigned alpha_w, beta_w;
  logic [11:0]     xs [NPTS];
  logic [11:0]     ys [NPTS];
  int unsigned     n_loaded;
  bit              dropped;
  int unsigned     sent_pct;
  longint unsigned cycles;
  int unsigned     results_seen;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      sb.check_result(res_o);
      results_seen++;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sadd(longint unsigned a, longint unsigned b,
                                           longint unsigned lim);
    if (a > lim || b > lim - a) return lim;
    return a + b;
  endfunction

  function automatic longint unsigned smul(longint unsigned a, longint unsigned b,
                                           longint unsigned lim);
    if (a != 0 && b > lim / a) return lim;
    return a * b;
  endfunction

  function automatic longint unsigned edge_length(int unsigned i, int unsigned j);
    longint unsigned dx, dy;
    dx = (xs[i] > xs[j]) ? 64'(xs[i]) - 64'(xs[j]) : 64'(xs[j]) - 64'(xs[i]);
    dy = (ys[i] > ys[j]) ? 64'(ys[i]) - 64'(ys[j]) : 64'(ys[j]) - 64'(ys[i]);
    return isqrt((dx * dx + dy * dy) << 16);
  endfunction

  function automatic longint unsigned bend_sq(longint unsigned a, longint unsigned b,
                                              longint unsigned c);
    longint unsigned s, t, m;
    s = a + c;
    t = 2 * b;
    m = (s > t) ? s - t : t - s;
    return m * m;
  endfunction

  // energy of the contour held in the point store
  function automatic snie_pkg::res_t contour_energy();
    snie_pkg::res_t r;
    int unsigned n, nx, pv;
    longint unsigned perim, avg, cont, curv, d16, dev, hi, lo, e, part;
    n = (n_loaded == 0) ? 1 : n_loaded;
    perim = 0; cont = 0; curv = 0;
    for (int unsigned i = 0; i < n; i++)
      perim += edge_length(i, (i + 1 == n) ? 0 : i + 1);
    avg = (perim << 8) / n;
    for (int unsigned i = 0; i < n; i++) begin
      nx = (i + 1 == n) ? 0 : i + 1;
      pv = (i == 0) ? n - 1 : i - 1;
      d16 = edge_length(i, nx) << 8;
      dev = (d16 > avg) ? d16 - avg : avg - d16;
      hi = dev >> 16;
      lo = dev & 64'hFFFF;
      cont = sadd(cont, ((hi * hi) << 16) + 2 * hi * lo + ((lo * lo) >> 16), '1);
      curv += bend_sq(64'(xs[nx]), 64'(xs[i]), 64'(xs[pv]));
      curv += bend_sq(64'(ys[nx]), 64'(ys[i]), 64'(ys[pv]));
    end
    part = smul(alpha_w, cont >> 8, EMAX);
    e = sadd(part, (alpha_w * (cont & 64'hFF)) >> 8, EMAX);
    part = smul(smul(beta_w, curv, EMAX), 256, EMAX);
    e = sadd(e, part, EMAX);
    r.energy = e[62:0];
    r.perimeter = (perim > PMAX) ? PMAX[28:0] : perim[28:0];
    r.point_count = n_loaded[8:0];
    r.overflow = dropped;
    return r;
  endfunction

  // send one point request, wait for acceptance, update prediction
  task automatic send_point(logic [11:0] x, logic [11:0] y, logic last);
    while ($urandom_range(99) < sent_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{point_x: x, point_y: y, last_point: last};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (n_loaded < NPTS) begin
      xs[n_loaded] = x;
      ys[n_loaded] = y;
      n_loaded++;
    end else dropped = 1'b1;
    if (last) begin
      sb.note_request(contour_energy());
      n_loaded = 0;
      dropped = 1'b0;
    end
  endtask

  // a contour of n points; kind picks coordinate shape
  task automatic send_contour(int unsigned n, int unsigned kind);
    logic [11:0] x, y, cx, cy;
    cx = 12'($urandom); cy = 12'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      case (kind)
        0: begin x = 12'($urandom); y = 12'($urandom); end
        1: begin x = cx + 12'($urandom_range(15)); y = cy + 12'($urandom_range(15)); end
        2: begin x = $urandom_range(1) ? 12'hFFF : 12'h000;
                 y = $urandom_range(1) ? 12'hFFF : 12'h000; end
        default: begin x = cx; y = cy; end
      endcase
      send_point(x, y, i + 1 == n);
    end
  endtask

  task automatic write_reg(snie_pkg::cfg_idx_e idx, logic [snie_pkg::WEIGHT_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == snie_pkg::CFG_CONT_WEIGHT) alpha_w = 64'(val);
    else beta_w = 64'(val);
  endtask

  // wait out all expected results, then the back end's tail
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned pct, int unsigned items);
    int unsigned sent, n, r;
    sent_pct = pct;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (r < 3) n = NPTS + $urandom_range(1, 6);
      else if (r < 8) n = $urandom_range(100, NPTS);
      else n = $urandom_range(1, 12);
      send_contour(n, $urandom_range(3));
      sent += n;
    end
  endtask

  initial begin
    sb = new();
    results_seen = 0;
    alpha_w = 1; beta_w = 1;
    n_loaded = 0; dropped = 1'b0;
    sent_pct = 0;
    start = 1'b0; req_i = '0;
    cfg_we_i = 1'b0; cfg_idx_i = snie_pkg::CFG_CONT_WEIGHT; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-point, two-point, three-point, extremes, coincident points, reset weights
    send_point(12'h000, 12'h000, 1'b1);
    send_point(12'hFFF, 12'hFFF, 1'b1);
    send_point(12'h000, 12'h000, 1'b0);
    send_point(12'hFFF, 12'hFFF, 1'b1);
    send_point(12'h000, 12'hFFF, 1'b0);
    send_point(12'hFFF, 12'h000, 1'b0);
    send_point(12'h555, 12'hAAA, 1'b1);
    send_contour(4, 2);
    send_contour(5, 3);
    drain();

    // extreme weights
    write_reg(snie_pkg::CFG_CONT_WEIGHT, 16'hFFFF);
    write_reg(snie_pkg::CFG_CURV_WEIGHT, 16'hFFFF);
    send_contour(6, 2);
    send_contour(3, 0);
    drain();
    write_reg(snie_pkg::CFG_CONT_WEIGHT, 16'h0000);
    write_reg(snie_pkg::CFG_CURV_WEIGHT, 16'h0000);
    send_contour(4, 0);
    drain();

    // store overflow with last on a dropped point
    write_reg(snie_pkg::CFG_CONT_WEIGHT, 16'd3);
    write_reg(snie_pkg::CFG_CURV_WEIGHT, 16'd7);
    send_contour(NPTS + 2, 0);
    drain();

    write_reg(snie_pkg::CFG_CONT_WEIGHT, 16'($urandom));
    write_reg(snie_pkg::CFG_CURV_WEIGHT, 16'($urandom));
    random_phase(22, 515);
    drain();
    write_reg(snie_pkg::CFG_CONT_WEIGHT, 16'hFFFF);
    write_reg(snie_pkg::CFG_CURV_WEIGHT, 16'($urandom_range(3)));
    random_phase(75, 515);
    drain();
    write_reg(snie_pkg::CFG_CONT_WEIGHT, 16'($urandom_range(3)));
    write_reg(snie_pkg::CFG_CURV_WEIGHT, 16'($urandom));
    random_phase(0, 515);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
